FILE: design/ssr_pkg.sv
// shared constants, types and helpers for the share reconstructor
`timescale 1ns / 1ps

package ssr_pkg;

    localparam int MAX_SHARES = 8;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int MU_SHIFT   = 27;
    localparam int MU_W       = 27;
    localparam int SUM_W      = 19;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECRET_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIME        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHARE_X      = 2'd3;

    // reset values
    localparam logic [3:0]            RST_THRESHOLD    = 4'd4;
    localparam logic [3:0]            RST_SECRET_BYTES = 4'd1;
    localparam logic [BYTE_W-1:0]     RST_PRIME        = 8'd251;
    localparam logic [CFG_DATA_W-1:0] RST_SHARE_X      = 64'h0807060504030201;

    // weight[m][j]: contribution of share m to coefficient j
    typedef logic [MAX_SHARES-1:0][MAX_SHARES-1:0][BYTE_W-1:0] weight_t;

    typedef struct packed {
        logic busy;
        logic err;
    } eng_status_t;

    // zero reads as one, anything above the share count as the share count
    function automatic logic [3:0] clamp_count(input logic [3:0] v);
        logic [3:0] r;
        if (v == 4'd0)
            r = 4'd1;
        else if (v > 4'(MAX_SHARES))
            r = 4'(MAX_SHARES);
        else
            r = v;
        return r;
    endfunction

endpackage

FILE: design/ssr_weight_engine.sv
// sequencer that derives lagrange weights and the reduction constant from configuration
`timescale 1ns / 1ps

module ssr_weight_engine
    import ssr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  restart,
    input  logic [3:0]            k,
    input  logic [BYTE_W-1:0]     prime,
    input  logic [CFG_DATA_W-1:0] x_vals,
    output eng_status_t           status,
    output weight_t               weights,
    output logic [MU_W-1:0]       mu
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MU    = 4'd1;
    localparam logic [3:0] ST_MM    = 4'd2;
    localparam logic [3:0] ST_XSW   = 4'd3;
    localparam logic [3:0] ST_MINIT = 4'd4;
    localparam logic [3:0] ST_LSEL  = 4'd5;
    localparam logic [3:0] ST_BASIS = 4'd6;
    localparam logic [3:0] ST_DEN   = 4'd7;
    localparam logic [3:0] ST_INV   = 4'd8;
    localparam logic [3:0] ST_PSEL  = 4'd9;
    localparam logic [3:0] ST_PR    = 4'd10;
    localparam logic [3:0] ST_PB    = 4'd11;
    localparam logic [3:0] ST_WGT   = 4'd12;

    logic [3:0]        state_reg, state_next;
    logic [3:0]        ret_reg, ret_next;
    logic              go_reg, go_next;
    logic              err_reg, err_next;
    logic [MU_W-1:0]   mu_reg, mu_next;
    logic [8:0]        rem_reg, rem_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [1:0]        ph_reg, ph_next;
    logic [7:0]        mm_a_reg, mm_a_next;
    logic [7:0]        mm_b_reg, mm_b_next;
    logic [15:0]       prod_reg, prod_next;
    logic [15:0]       q_reg, q_next;
    logic [8:0]        rr_reg, rr_next;
    logic [7:0]        res_reg, res_next;
    logic [7:0]        xs_reg [MAX_SHARES];
    logic [7:0]        xs_next [MAX_SHARES];
    logic [7:0]        basis_reg [MAX_SHARES];
    logic [7:0]        basis_next [MAX_SHARES];
    logic [2:0]        idx_reg, idx_next;
    logic [2:0]        m_reg, m_next;
    logic [3:0]        l_reg, l_next;
    logic [2:0]        j_reg, j_next;
    logic [7:0]        carry_reg, carry_next;
    logic [7:0]        a_reg, a_next;
    logic [7:0]        xm_reg, xm_next;
    logic [7:0]        den_reg, den_next;
    logic [7:0]        r_reg, r_next;
    logic [7:0]        b_reg, b_next;
    logic [7:0]        e_reg, e_next;
    weight_t           w_reg, w_next;

    logic [2:0]        xs_addr;
    logic [7:0]        xs_rd;
    logic [42:0]       mm_t;
    logic [15:0]       mm_diff;
    logic [8:0]        div_shift;
    logic [8:0]        bsum;
    logic [7:0]        bnew;
    logic [8:0]        dsum;
    logic [7:0]        dval;
    logic [2:0]        nidx;

    // single read port on the reduced x coordinates
    assign xs_addr = (state_reg == ST_MINIT) ? m_reg : l_reg[2:0];
    assign xs_rd   = xs_reg[xs_addr];

    // datapath pieces of the shared mulmod unit and the small subtractions
    assign mm_t      = 43'(prod_reg) * 43'(mu_reg);
    assign mm_diff   = prod_reg - 16'(q_reg * 16'(prime));
    assign div_shift = {rem_reg[7:0], (cnt_reg == 5'(MU_SHIFT))};
    assign bsum      = 9'(carry_reg) + 9'(prime) - 9'(res_reg);
    assign bnew      = (bsum >= 9'(prime)) ? 8'(bsum - 9'(prime)) : bsum[7:0];
    assign dsum      = 9'(xm_reg) + 9'(prime) - 9'(a_reg);
    assign dval      = (dsum >= 9'(prime)) ? 8'(dsum - 9'(prime)) : dsum[7:0];
    assign nidx      = idx_reg + 3'd1;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        go_next    = go_reg;
        err_next   = err_reg;
        mu_next    = mu_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        ph_next    = ph_reg;
        mm_a_next  = mm_a_reg;
        mm_b_next  = mm_b_reg;
        prod_next  = prod_reg;
        q_next     = q_reg;
        rr_next    = rr_reg;
        res_next   = res_reg;
        xs_next    = xs_reg;
        basis_next = basis_reg;
        idx_next   = idx_reg;
        m_next     = m_reg;
        l_next     = l_reg;
        j_next     = j_reg;
        carry_next = carry_reg;
        a_next     = a_reg;
        xm_next    = xm_reg;
        den_next   = den_reg;
        r_next     = r_reg;
        b_next     = b_reg;
        e_next     = e_reg;
        w_next     = w_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (go_reg)
                begin
                    go_next  = 1'b0;
                    w_next   = '0;
                    err_next = 1'b0;
                    if (prime < 8'd2)
                        err_next = 1'b1;
                    else
                    begin
                        rem_next   = '0;
                        mu_next    = '0;
                        cnt_next   = 5'(MU_SHIFT);
                        state_next = ST_MU;
                    end
                end
            end
            ST_MU:
            begin
                // restoring division for the reduction constant
                if (div_shift >= 9'(prime))
                begin
                    rem_next = div_shift - 9'(prime);
                    mu_next  = {mu_reg[MU_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_shift;
                    mu_next  = {mu_reg[MU_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    idx_next   = 3'd0;
                    mm_a_next  = x_vals[7:0];
                    mm_b_next  = 8'd1;
                    ret_next   = ST_XSW;
                    state_next = ST_MM;
                end
            end
            ST_MM:
            begin
                // multiply then barrett reduce, one step per cycle
                ph_next = ph_reg + 2'd1;
                case (ph_reg)
                    2'd0: prod_next = 16'(mm_a_reg) * 16'(mm_b_reg);
                    2'd1: q_next    = mm_t[42:MU_SHIFT];
                    2'd2: rr_next   = mm_diff[8:0];
                    default:
                    begin
                        res_next   = (rr_reg >= 9'(prime)) ? 8'(rr_reg - 9'(prime))
                                                            : rr_reg[7:0];
                        state_next = ret_reg;
                    end
                endcase
            end
            ST_XSW:
            begin
                xs_next[idx_reg] = res_reg;
                idx_next         = nidx;
                if (idx_reg == 3'(MAX_SHARES - 1))
                begin
                    m_next     = 3'd0;
                    state_next = ST_MINIT;
                end
                else
                begin
                    mm_a_next  = x_vals[nidx*8 +: 8];
                    mm_b_next  = 8'd1;
                    ret_next   = ST_XSW;
                    state_next = ST_MM;
                end
            end
            ST_MINIT:
            begin
                xm_next = xs_rd;
                for (int i = 0; i < MAX_SHARES; i++)
                    basis_next[i] = (i == 0) ? 8'd1 : 8'd0;
                den_next   = 8'd1;
                l_next     = 4'd0;
                state_next = ST_LSEL;
            end
            ST_LSEL:
            begin
                if (l_reg == 4'(MAX_SHARES))
                    state_next = ST_INV;
                else if (l_reg[2:0] == m_reg || l_reg >= k)
                    l_next = l_reg + 4'd1;
                else
                begin
                    a_next     = xs_rd;
                    j_next     = 3'd0;
                    carry_next = 8'd0;
                    mm_a_next  = xs_rd;
                    mm_b_next  = basis_reg[0];
                    ret_next   = ST_BASIS;
                    state_next = ST_MM;
                end
            end
            ST_BASIS:
            begin
                // multiply the basis polynomial by (x - a), one term per pass
                for (int i = 0; i < MAX_SHARES - 1; i++)
                    basis_next[i] = basis_reg[i+1];
                basis_next[MAX_SHARES-1] = bnew;
                carry_next = basis_reg[0];
                j_next     = j_reg + 3'd1;
                if (j_reg == 3'(MAX_SHARES - 1))
                begin
                    mm_a_next = den_reg;
                    mm_b_next = dval;
                    ret_next  = ST_DEN;
                end
                else
                begin
                    mm_a_next = a_reg;
                    mm_b_next = basis_reg[1];
                    ret_next  = ST_BASIS;
                end
                state_next = ST_MM;
            end
            ST_DEN:
            begin
                den_next   = res_reg;
                l_next     = l_reg + 4'd1;
                state_next = ST_LSEL;
            end
            ST_INV:
            begin
                if (den_reg == 8'd0)
                begin
                    err_next   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    r_next     = 8'd1;
                    b_next     = den_reg;
                    e_next     = prime - 8'd2;
                    state_next = ST_PSEL;
                end
            end
            ST_PSEL:
            begin
                // fermat power, low exponent bit first
                if (e_reg == 8'd0)
                begin
                    j_next    = 3'd0;
                    mm_a_next = r_reg;
                    mm_b_next = basis_reg[0];
                    ret_next  = ST_WGT;
                end
                else if (e_reg[0])
                begin
                    mm_a_next = r_reg;
                    mm_b_next = b_reg;
                    ret_next  = ST_PR;
                end
                else
                begin
                    mm_a_next = b_reg;
                    mm_b_next = b_reg;
                    ret_next  = ST_PB;
                end
                state_next = ST_MM;
            end
            ST_PR:
            begin
                r_next     = res_reg;
                mm_a_next  = b_reg;
                mm_b_next  = b_reg;
                ret_next   = ST_PB;
                state_next = ST_MM;
            end
            ST_PB:
            begin
                b_next     = res_reg;
                e_next     = {1'b0, e_reg[7:1]};
                state_next = ST_PSEL;
            end
            ST_WGT:
            begin
                w_next[m_reg][j_reg] = res_reg;
                for (int i = 0; i < MAX_SHARES - 1; i++)
                    basis_next[i] = basis_reg[i+1];
                basis_next[MAX_SHARES-1] = basis_reg[0];
                if (j_reg == 3'(MAX_SHARES - 1))
                begin
                    if (4'(m_reg) == k - 4'd1)
                        state_next = ST_IDLE;
                    else
                    begin
                        m_next     = m_reg + 3'd1;
                        state_next = ST_MINIT;
                    end
                end
                else
                begin
                    j_next     = j_reg + 3'd1;
                    mm_a_next  = r_reg;
                    mm_b_next  = basis_reg[1];
                    ret_next   = ST_WGT;
                    state_next = ST_MM;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (restart)
            go_next = 1'b1;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            go_reg    <= 1'b1;
            err_reg   <= 1'b0;
            ph_reg    <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            go_reg    <= go_next;
            err_reg   <= err_next;
            ph_reg    <= ph_next;
        end
    end

    // working values
    always_ff @(posedge clk)
    begin
        mu_reg    <= mu_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        mm_a_reg  <= mm_a_next;
        mm_b_reg  <= mm_b_next;
        prod_reg  <= prod_next;
        q_reg     <= q_next;
        rr_reg    <= rr_next;
        res_reg   <= res_next;
        xs_reg    <= xs_next;
        basis_reg <= basis_next;
        idx_reg   <= idx_next;
        m_reg     <= m_next;
        l_reg     <= l_next;
        j_reg     <= j_next;
        carry_reg <= carry_next;
        a_reg     <= a_next;
        xm_reg    <= xm_next;
        den_reg   <= den_next;
        r_reg     <= r_next;
        b_reg     <= b_next;
        e_reg     <= e_next;
        w_reg     <= w_next;
    end

    assign status.busy = go_reg | (state_reg != ST_IDLE);
    assign status.err  = err_reg;
    assign weights     = w_reg;
    assign mu          = mu_reg;

endmodule

FILE: design/secret_share_reconstructor.sv
// top level: configuration, seven-stage interpolation pipeline and result serializer
`timescale 1ns / 1ps

// After reset and after every configuration write, busy stays high while the
// block derives the Lagrange weights in a sequential engine with one shared
// multiply-and-reduce unit, up to about 700 modular products for eight shares.
// Once busy falls, a transaction is taken on any cycle with start high and busy
// low. Each item passes seven register stages (input, weight products, two adder
// levels, reciprocal multiply, subtract, correction) and then produces
// secret_bytes_per_block results, one per cycle, on strobe. The receiver cannot
// stall, so the result serializer sets the pace: one item per cycle when one byte
// is emitted per item and the engine is idle; otherwise a new item moves on only
// as the serializer emits the previous one's last byte. A zero denominator or a
// modulus below two gives one result per item with error and last set, byte zero.

module secret_share_reconstructor
    import ssr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [BYTE_W-1:0]     share_0,
    input  logic [BYTE_W-1:0]     share_1,
    input  logic [BYTE_W-1:0]     share_2,
    input  logic [BYTE_W-1:0]     share_3,
    input  logic [BYTE_W-1:0]     share_4,
    input  logic [BYTE_W-1:0]     share_5,
    input  logic [BYTE_W-1:0]     share_6,
    input  logic [BYTE_W-1:0]     share_7,
    output logic                  strobe,
    output logic [BYTE_W-1:0]     secret_byte,
    output logic                  last,
    output logic                  error
);

    logic [3:0]            threshold_reg;
    logic [3:0]            count_reg;
    logic [BYTE_W-1:0]     prime_reg;
    logic [CFG_DATA_W-1:0] xvals_reg;
    logic [3:0]            k;
    logic [3:0]            cnt;
    eng_status_t           eng;
    weight_t               w;
    logic [MU_W-1:0]       mu;
    logic                  accept;
    logic                  adv;

    logic [BYTE_W-1:0] shares [MAX_SHARES];
    logic [BYTE_W-1:0] y_reg  [MAX_SHARES];
    logic [15:0]       p2_reg [MAX_SHARES][MAX_SHARES];
    logic [16:0]       s3_reg [MAX_SHARES][MAX_SHARES/2];
    logic [SUM_W-1:0]  s4_reg [MAX_SHARES];
    logic [SUM_W-1:0]  x5_reg [MAX_SHARES];
    logic [45:0]       t5_reg [MAX_SHARES];
    logic [8:0]        r6_reg [MAX_SHARES];
    logic [7:0]        c7_reg [MAX_SHARES];
    logic [6:0]        v_reg;

    logic [7:0]        ser_bytes_reg [MAX_SHARES];
    logic [3:0]        ser_left_reg;
    logic              ser_err_reg;

    assign shares[0] = share_0;
    assign shares[1] = share_1;
    assign shares[2] = share_2;
    assign shares[3] = share_3;
    assign shares[4] = share_4;
    assign shares[5] = share_5;
    assign shares[6] = share_6;
    assign shares[7] = share_7;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= RST_THRESHOLD;
            count_reg     <= RST_SECRET_BYTES;
            prime_reg     <= RST_PRIME;
            xvals_reg     <= RST_SHARE_X;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:    threshold_reg <= cfg_data[3:0];
                REG_SECRET_BYTES: count_reg     <= cfg_data[3:0];
                REG_PRIME:        prime_reg     <= cfg_data[7:0];
                REG_SHARE_X:      xvals_reg     <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign k   = clamp_count(threshold_reg);
    assign cnt = clamp_count(count_reg);

    ssr_weight_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_we),
        .k       (k),
        .prime   (prime_reg),
        .x_vals  (xvals_reg),
        .status  (eng),
        .weights (w),
        .mu      (mu)
    );

    // whole pipeline moves when the serializer can take the oldest item
    assign adv    = !v_reg[6] || (ser_left_reg <= 4'd1);
    assign busy   = eng.busy || !adv;
    assign accept = start && !busy;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[5:0], accept};
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int m = 0; m < MAX_SHARES; m++)
                y_reg[m] <= shares[m];
            for (int j = 0; j < MAX_SHARES; j++)
            begin
                for (int m = 0; m < MAX_SHARES; m++)
                    p2_reg[j][m] <= 16'(y_reg[m]) * 16'(w[m][j]);
                for (int h = 0; h < MAX_SHARES/2; h++)
                    s3_reg[j][h] <= 17'(p2_reg[j][2*h]) + 17'(p2_reg[j][2*h+1]);
                s4_reg[j] <= SUM_W'(s3_reg[j][0]) + SUM_W'(s3_reg[j][1])
                           + SUM_W'(s3_reg[j][2]) + SUM_W'(s3_reg[j][3]);
                x5_reg[j] <= s4_reg[j];
                t5_reg[j] <= 46'(s4_reg[j]) * 46'(mu);
                r6_reg[j] <= 9'(x5_reg[j] - SUM_W'(t5_reg[j][45:MU_SHIFT]
                                                  * SUM_W'(prime_reg)));
                c7_reg[j] <= (r6_reg[j] >= 9'(prime_reg))
                           ? 8'(r6_reg[j] - 9'(prime_reg)) : r6_reg[j][7:0];
            end
        end
    end

    // result serializer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_left_reg <= '0;
            ser_err_reg  <= 1'b0;
        end
        else if (adv && v_reg[6])
        begin
            ser_left_reg <= eng.err ? 4'd1 : cnt;
            ser_err_reg  <= eng.err;
        end
        else if (ser_left_reg != 4'd0)
            ser_left_reg <= ser_left_reg - 4'd1;
    end

    // result serializer bytes
    always_ff @(posedge clk)
    begin
        if (adv && v_reg[6])
        begin
            for (int j = 0; j < MAX_SHARES; j++)
                ser_bytes_reg[j] <= eng.err ? 8'd0 : c7_reg[j];
        end
        else
        begin
            for (int j = 0; j < MAX_SHARES - 1; j++)
                ser_bytes_reg[j] <= ser_bytes_reg[j+1];
            ser_bytes_reg[MAX_SHARES-1] <= 8'd0;
        end
    end

    assign strobe      = (ser_left_reg != 4'd0);
    assign secret_byte = ser_bytes_reg[0];
    assign last        = (ser_left_reg == 4'd1);
    assign error       = ser_err_reg;

    // a run of results never breaks before its last byte
    assert property (@(posedge clk) disable iff (!rst_n) strobe && !last |=> strobe)
        else $error("result run broken before last");

    // an error result stands alone and carries a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
                     strobe && error |-> last && (secret_byte == 8'd0))
        else $error("error result not single or nonzero");

    // no item enters while the weights are being rebuilt
    assert property (@(posedge clk) disable iff (!rst_n)
                     eng.busy |=> !v_reg[0] || !$past(accept))
        else $error("item accepted during weight rebuild");

endmodule

FILE: tb/sv/tb_secret_share_reconstructor.sv
// self-checking testbench for the secret share reconstructor
`timescale 1ns / 1ps

module tb_secret_share_reconstructor;
    import ssr_pkg::*;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct {
        logic [3:0]            thr;
        logic [3:0]            cnt;
        byte_t                 prime;
        logic [CFG_DATA_W-1:0] xs;
    } field_cfg_t;

    typedef struct {
        byte_t secret;
        logic  last;
        logic  err;
    } secret_t;

    typedef struct {
        int      cfg_sel;
        byte_t   sh [MAX_SHARES];
        bit      has_exp;
        secret_t exp;
    } stim_row_t;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 20;
    localparam int N_RANDOM    = 150;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  start;
    logic                  busy;
    byte_t                 share_d [MAX_SHARES];
    logic                  strobe;
    byte_t                 secret_byte;
    logic                  last;
    logic                  error;

    // local copy of the register file
    logic [3:0]            thr_q;
    logic [3:0]            cnt_q;
    byte_t                 prime_q;
    logic [CFG_DATA_W-1:0] xs_q;

    secret_t    pending_secrets [$];
    int         mismatch_count;
    int         cycle_count;
    field_cfg_t cfg_list [6];
    stim_row_t  dir_rows [$];
    int         cur_cfg;

    secret_share_reconstructor dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start       (start),
        .busy        (busy),
        .share_0     (share_d[0]),
        .share_1     (share_d[1]),
        .share_2     (share_d[2]),
        .share_3     (share_d[3]),
        .share_4     (share_d[4]),
        .share_5     (share_d[5]),
        .share_6     (share_d[6]),
        .share_7     (share_d[7]),
        .strobe      (strobe),
        .secret_byte (secret_byte),
        .last        (last),
        .error       (error)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run length guard
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic int count_clamp(input logic [3:0] v);
        int r;
        if (v == 4'd0)
            r = 1;
        else if (v > 4'(MAX_SHARES))
            r = MAX_SHARES;
        else
            r = int'(v);
        return r;
    endfunction

    function automatic int fermat_pow(input int b, input int e, input int p);
        int r;
        r = 1 % p;
        b = b % p;
        while (e > 0)
        begin
            if (e & 1)
                r = (r * b) % p;
            b = (b * b) % p;
            e = e >> 1;
        end
        return r;
    endfunction

    // lagrange interpolation over the current field, queues the expected run
    function automatic void predict_secrets(input byte_t sh [MAX_SHARES]);
        int      k, n, p, deg, den, y, a, scale, hi, lo;
        int      xs [MAX_SHARES];
        int      coef [MAX_SHARES];
        int      basis [MAX_SHARES+1];
        bit      bad;
        secret_t s;
        k   = count_clamp(thr_q);
        n   = count_clamp(cnt_q);
        p   = int'(prime_q);
        bad = (p < 2);
        if (!bad)
        begin
            for (int m = 0; m < k; m++)
                xs[m] = int'(xs_q[8*m +: 8]) % p;
            foreach (coef[j])
                coef[j] = 0;
            for (int m = 0; m < k && !bad; m++)
            begin
                y   = int'(sh[m]) % p;
                deg = 0;
                den = 1;
                foreach (basis[j])
                    basis[j] = 0;
                basis[0] = 1;
                for (int l = 0; l < k; l++)
                begin
                    if (l != m)
                    begin
                        a = xs[l];
                        deg++;
                        // multiply basis by (x - a)
                        for (int j = deg; j >= 0; j--)
                        begin
                            hi = (j > 0) ? basis[j-1] : 0;
                            lo = (j < deg) ? (a * basis[j]) % p : 0;
                            basis[j] = (hi + p - lo) % p;
                        end
                        den = (den * ((xs[m] + p - a) % p)) % p;
                    end
                end
                if (den == 0)
                    bad = 1;
                else
                begin
                    scale = (y * fermat_pow(den, p - 2, p)) % p;
                    for (int j = 0; j <= deg && j < MAX_SHARES; j++)
                        coef[j] = (coef[j] + (scale * basis[j]) % p) % p;
                end
            end
        end
        if (bad)
        begin
            s.secret = '0;
            s.last   = 1'b1;
            s.err    = 1'b1;
            pending_secrets = {pending_secrets, s};
        end
        else
        begin
            for (int j = 0; j < n; j++)
            begin
                s.secret = (j < k) ? byte_t'(coef[j]) : '0;
                s.last   = (j + 1 == n);
                s.err    = 1'b0;
                pending_secrets = {pending_secrets, s};
            end
        end
    endfunction

    // result checker, receiver never stalls
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (pending_secrets.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0d/%0b/%0b",
                         $time, secret_byte, last, error);
                mismatch_count++;
            end
            else
            begin
                secret_t e;
                e = pending_secrets.pop_front();
                if (secret_byte !== e.secret || last !== e.last || error !== e.err)
                begin
                    $display("%0t: mismatch, expected %0d/%0b/%0b, actual %0d/%0b/%0b",
                             $time, e.secret, e.last, e.err, secret_byte, last, error);
                    mismatch_count++;
                end
            end
        end
    end

    // drain the pipeline, then write all four registers back to back
    task automatic write_field_cfg(input field_cfg_t c);
        start <= 1'b0;
        while (pending_secrets.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_THRESHOLD;
        cfg_data  <= {{60{1'b0}}, c.thr} | ({$urandom, $urandom} & ~64'hF);
        @(posedge clk);
        cfg_index <= REG_SECRET_BYTES;
        cfg_data  <= {{60{1'b0}}, c.cnt} | ({$urandom, $urandom} & ~64'hF);
        @(posedge clk);
        cfg_index <= REG_PRIME;
        cfg_data  <= {{56{1'b0}}, c.prime} | ({$urandom, $urandom} & ~64'hFF);
        @(posedge clk);
        cfg_index <= REG_SHARE_X;
        cfg_data  <= c.xs;
        @(posedge clk);
        cfg_we <= 1'b0;
        thr_q   = c.thr;
        cnt_q   = c.cnt;
        prime_q = c.prime;
        xs_q    = c.xs;
    endtask

    // one transaction; called just after clk rises
    task automatic send_shares(input byte_t sh [MAX_SHARES], input bit has_exp,
                               input secret_t e, input bit may_idle);
        start <= 1'b1;
        for (int m = 0; m < MAX_SHARES; m++)
            share_d[m] <= sh[m];
        do
            @(posedge clk);
        while (busy);
        if (has_exp)
            pending_secrets = {pending_secrets, e};
        else
            predict_secrets(sh);
        if (may_idle && $urandom_range(99) < 30)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
    endtask

    function automatic field_cfg_t random_field_cfg();
        field_cfg_t c;
        byte_t      primes [10] = '{2, 3, 5, 7, 11, 13, 101, 127, 251, 241};
        byte_t      x;
        bit         clash;
        c.thr = 4'($urandom_range(15));
        c.cnt = 4'($urandom_range(15));
        if ($urandom_range(99) < 75)
        begin
            c.prime = primes[$urandom_range(4, 9)];
            // distinct coordinates mod p
            for (int m = 0; m < MAX_SHARES; m++)
            begin
                do
                begin
                    x     = byte_t'($urandom_range(255));
                    clash = 0;
                    for (int l = 0; l < m; l++)
                        if (c.xs[8*l +: 8] % c.prime == x % c.prime)
                            clash = 1;
                end
                while (clash);
                c.xs[8*m +: 8] = x;
            end
        end
        else
        begin
            c.prime = ($urandom_range(1)) ? primes[$urandom_range(0, 9)] : byte_t'($urandom);
            c.xs    = {$urandom, $urandom};
        end
        return c;
    endfunction

    function automatic void add_row(input int sel, input byte_t v, input bit fill,
                                    input bit has_exp, input byte_t eb, input logic ee);
        stim_row_t r;
        r.cfg_sel = sel;
        for (int m = 0; m < MAX_SHARES; m++)
            r.sh[m] = fill ? v : byte_t'($urandom);
        r.has_exp    = has_exp;
        r.exp.secret = eb;
        r.exp.last   = 1'b1;
        r.exp.err    = ee;
        dir_rows = {dir_rows, r};
    endfunction

    // stimulus
    initial
    begin
        field_cfg_t c;
        byte_t      sh [MAX_SHARES];
        secret_t    none;
        bit         calm;
        mismatch_count = 0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        start     = 1'b0;
        foreach (share_d[m])
            share_d[m] = '0;
        none      = '{secret: '0, last: 1'b0, err: 1'b0};
        thr_q     = RST_THRESHOLD;
        cnt_q     = RST_SECRET_BYTES;
        prime_q   = RST_PRIME;
        xs_q      = RST_SHARE_X;

        // directed settings: reset values, widest, degenerate modulus,
        // duplicate coordinates, zero counts, counts above range with composite modulus
        cfg_list[0] = '{RST_THRESHOLD, RST_SECRET_BYTES, RST_PRIME, RST_SHARE_X};
        cfg_list[1] = '{4'd8, 4'd8, 8'd251, 64'hFF00_7F80_0102_FEFD};
        cfg_list[2] = '{4'd4, 4'd1, 8'd1, RST_SHARE_X};
        cfg_list[3] = '{4'd3, 4'd2, 8'd251, 64'h0000_0000_0005_0505};
        cfg_list[4] = '{4'd0, 4'd0, 8'd2, RST_SHARE_X};
        cfg_list[5] = '{4'd15, 4'd15, 8'd255, 64'h1F2E_3D4C_5B6A_7988};

        // directed table; constant shares give a constant polynomial
        add_row(0, 8'h00, 1, 1, 8'd0, 1'b0);
        add_row(0, 8'hFF, 1, 1, 8'd4, 1'b0);
        add_row(0, 8'hFA, 1, 1, 8'd250, 1'b0);
        add_row(0, 8'hFB, 1, 1, 8'd0, 1'b0);
        add_row(0, 8'h00, 0, 0, 8'd0, 1'b0);
        add_row(0, 8'h00, 0, 0, 8'd0, 1'b0);
        add_row(1, 8'h07, 1, 0, 8'd0, 1'b0);
        add_row(1, 8'hFF, 1, 0, 8'd0, 1'b0);
        add_row(1, 8'h00, 0, 0, 8'd0, 1'b0);
        add_row(1, 8'h00, 0, 0, 8'd0, 1'b0);
        add_row(2, 8'h55, 1, 1, 8'd0, 1'b1);
        add_row(2, 8'h00, 0, 1, 8'd0, 1'b1);
        add_row(3, 8'hAA, 1, 1, 8'd0, 1'b1);
        add_row(3, 8'h00, 0, 1, 8'd0, 1'b1);
        add_row(4, 8'hFF, 1, 1, 8'd1, 1'b0);
        add_row(4, 8'hFE, 1, 1, 8'd0, 1'b0);
        add_row(4, 8'h00, 0, 0, 8'd0, 1'b0);
        add_row(5, 8'hFF, 1, 0, 8'd0, 1'b0);
        add_row(5, 8'h00, 0, 0, 8'd0, 1'b0);
        add_row(5, 8'h00, 0, 0, 8'd0, 1'b0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, register values from reset for the first rows
        cur_cfg = 0;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg_sel != cur_cfg)
            begin
                cur_cfg = dir_rows[i].cfg_sel;
                write_field_cfg(cfg_list[cur_cfg]);
            end
            send_shares(dir_rows[i].sh, dir_rows[i].has_exp, dir_rows[i].exp, 1'b1);
        end

        // random part: new field every dozen items, no idle gaps in the middle stretch
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 12 == 0)
            begin
                if (i == 72)
                    c = cfg_list[1];
                else if (i == 144)
                    c = cfg_list[0];
                else
                    c = random_field_cfg();
                write_field_cfg(c);
            end
            for (int m = 0; m < MAX_SHARES; m++)
                sh[m] = byte_t'($urandom);
            calm = (i >= 60 && i < 110);
            send_shares(sh, 1'b0, none, !calm);
        end
        start <= 1'b0;

        // drain
        while (pending_secrets.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
